>>> rtl/core/mmsp_pkg.sv
// Package for the motor mode sequencer: mode codes, button codes, widths.
// No dependencies.
package mmsp_pkg;

  localparam int unsigned AccW = 48;

  typedef enum logic [3:0] {
    MODE_STOP_FWD  = 4'd0,
    MODE_STOP_REV  = 4'd1,
    MODE_ACCEL_CW  = 4'd2,
    MODE_ACCEL_CCW = 4'd3,
    MODE_RUN_CW    = 4'd4,
    MODE_RUN_CCW   = 4'd5,
    MODE_REV_CW    = 4'd6,
    MODE_REV_CCW   = 4'd7,
    MODE_BRAKE_CW  = 4'd8,
    MODE_BRAKE_CCW = 4'd9
  } mode_e;

  localparam logic [1:0] BTN_R = 2'd1;
  localparam logic [1:0] BTN_S = 2'd2;

  localparam logic [1:0] DIR_CW  = 2'd1;
  localparam logic [1:0] DIR_CCW = 2'd2;

  localparam logic [1:0] CFG_GAIN_P = 2'd0;
  localparam logic [1:0] CFG_GAIN_I = 2'd1;
  localparam logic [1:0] CFG_GAIN_D = 2'd2;

  // Controller to datapath
  typedef struct packed {
    logic load;   // capture input word, start multiplies
    logic step;   // advance datapath sequence one phase
    logic div_go; // start the divider
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic div_done;
  } dp_sts_t;

endpackage

>>> rtl/core/mmsp_datapath.sv
// PID datapath: shared multiplier, serial divider, integral and duty registers.
// Depends on mmsp_pkg.
module mmsp_datapath
  import mmsp_pkg::*;
#(
  parameter int unsigned DutyMax = 4095
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [31:0] cfg_data_i,
  input  dp_cmd_t     cmd_i,
  input  logic [2:0]  phase_i,
  input  logic        pid_en_i,
  input  logic [15:0] meas_i,
  input  logic [15:0] target_i,
  input  logic [15:0] elapsed_i,
  output dp_sts_t     sts_o,
  output logic [11:0] duty_o
);

  localparam int unsigned DutyW = $clog2(DutyMax + 1);
  localparam logic signed [AccW-1:0] AccMax = {1'b0, {(AccW-1){1'b1}}};
  localparam logic signed [AccW-1:0] AccMin = {1'b1, {(AccW-1){1'b0}}};
  // Increment limits: twice the accumulator limits
  localparam logic signed [AccW+1:0] IncMax = {1'b0, AccMax, 1'b0};
  localparam logic signed [AccW+1:0] IncMin = {1'b1, AccMin, 1'b0};

  logic [31:0] gain_p_q, gain_i_q, gain_d_q;
  logic signed [16:0] err_q, dsp_q;
  logic [15:0] prev_q, el_q;
  logic signed [AccW-1:0] acc_q;
  logic signed [49:0] p_q;
  logic signed [AccW-1:0] ei_q;
  logic signed [AccW+1:0] d_q;
  logic [DutyW-1:0] duty_q;

  // Gain registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_p_q <= 32'd65536;
      gain_i_q <= 32'd0;
      gain_d_q <= 32'd6554;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_GAIN_P: gain_p_q <= cfg_data_i;
        CFG_GAIN_I: gain_i_q <= cfg_data_i;
        CFG_GAIN_D: gain_d_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Shared 17x33 signed multiplier, operands chosen by phase
  logic signed [17:0] mul_a;
  logic signed [33:0] mul_b;
  logic signed [51:0] mul_y;
  always_comb begin
    case (phase_i)
      3'd0:    begin mul_a = 18'(err_q); mul_b = $signed({2'b00, gain_p_q}); end
      3'd1:    begin mul_a = 18'(err_q); mul_b = $signed({2'b00, gain_i_q}); end
      default: begin mul_a = 18'(dsp_q); mul_b = $signed({2'b00, gain_d_q}); end
    endcase
    mul_y = mul_a * mul_b;
  end

  // err*gain_i saturated to 48 bits, times elapsed (|ei| < 2^48, el < 2^16)
  logic signed [65:0] inc_full;
  logic signed [AccW+1:0] inc_c;
  logic signed [AccW+1:0] acc_sum;
  assign inc_full = ei_q * $signed({1'b0, el_q});
  always_comb begin
    if (inc_full > 66'(IncMax))
      inc_c = IncMax;
    else if (inc_full < 66'(IncMin))
      inc_c = IncMin;
    else
      inc_c = inc_full[AccW+1:0];
    acc_sum = 50'(acc_q) + inc_c;
  end

  // Restoring divider for |dn| / elapsed; zero elapsed divides by one
  logic [49:0] dv_rem_num, dv_quo;
  logic [16:0] dv_part;
  logic [5:0]  dv_cnt;
  logic        dv_neg, dv_busy;
  logic [16:0] dv_trial;
  logic [15:0] dv_den;
  assign dv_trial = {dv_part[15:0], dv_rem_num[49]};
  assign dv_den   = (el_q == 16'd0) ? 16'd1 : el_q;

  // Final sum and clamp
  logic signed [51:0] sum;
  logic [DutyW-1:0] duty_n;
  always_comb begin
    sum = 52'(p_q) + 52'(acc_q) + 52'(d_q);
    if (sum[51]) duty_n = '0;
    else if (sum[51:16] > 36'(DutyMax)) duty_n = DutyW'(DutyMax);
    else duty_n = sum[16+DutyW-1:16];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q      <= '0;
      prev_q     <= '0;
      duty_q     <= '0;
      dv_busy    <= 1'b0;
      dv_cnt     <= '0;
      err_q      <= '0;
      dsp_q      <= '0;
      el_q       <= '0;
      p_q        <= '0;
      ei_q       <= '0;
      d_q        <= '0;
      dv_rem_num <= '0;
      dv_quo     <= '0;
      dv_part    <= '0;
      dv_neg     <= 1'b0;
    end else begin
      if (cmd_i.load) begin
        err_q  <= $signed({1'b0, target_i}) - $signed({1'b0, meas_i});
        dsp_q  <= $signed({1'b0, prev_q}) - $signed({1'b0, meas_i});
        el_q   <= elapsed_i;
        prev_q <= meas_i;
      end
      if (cmd_i.step && pid_en_i) begin
        case (phase_i)
          3'd0: p_q <= mul_y[49:0];
          3'd1: begin
            if (mul_y > 52'(AccMax)) ei_q <= AccMax;
            else if (mul_y < 52'(AccMin)) ei_q <= AccMin;
            else ei_q <= mul_y[AccW-1:0];
          end
          3'd2: begin
            dv_rem_num <= mul_y[51] ? 50'(-mul_y) : mul_y[49:0];
            dv_neg     <= mul_y[51];
          end
          3'd3: begin
            if (acc_sum > 50'(AccMax)) acc_q <= AccMax;
            else if (acc_sum < 50'(AccMin)) acc_q <= AccMin;
            else acc_q <= acc_sum[AccW-1:0];
          end
          3'd4: d_q <= dv_neg ? -$signed(dv_quo) : $signed(dv_quo);
          3'd5: duty_q <= duty_n;
          default: ;
        endcase
      end
      // one quotient bit per cycle
      if (cmd_i.div_go) begin
        dv_busy <= 1'b1;
        dv_cnt  <= 6'd50;
        dv_part <= '0;
      end else if (dv_busy) begin
        dv_rem_num <= {dv_rem_num[48:0], 1'b0};
        if (dv_trial >= {1'b0, dv_den}) begin
          dv_part <= dv_trial - {1'b0, dv_den};
          dv_quo  <= {dv_quo[48:0], 1'b1};
        end else begin
          dv_part <= dv_trial;
          dv_quo  <= {dv_quo[48:0], 1'b0};
        end
        dv_cnt <= dv_cnt - 6'd1;
        if (dv_cnt == 6'd1) dv_busy <= 1'b0;
      end
    end
  end

  // el_q keeps the raw elapsed, so a zero elapsed adds nothing to the integral
  assign sts_o.div_done = !dv_busy && !cmd_i.div_go;
  assign duty_o = 12'(duty_q);

endmodule

>>> rtl/core/mmsp_ctrl.sv
// Mode state machine and PID sequencer.
// Depends on mmsp_pkg.
module mmsp_ctrl
  import mmsp_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_fire_i,
  input  logic [1:0]  button_i,
  input  logic        meas_zero_i,
  input  dp_sts_t     sts_i,
  input  logic        out_free_i,
  output dp_cmd_t     cmd_o,
  output logic [2:0]  phase_o,
  output logic        pid_en_o,
  output logic        busy_o,
  output logic        done_o,
  output logic [3:0]  mode_o,
  output logic [1:0]  dir_o
);

  typedef enum logic [2:0] {
    ST_IDLE, ST_MUL, ST_DIV, ST_FIN, ST_OUT
  } state_e;

  state_e state_q;
  logic [2:0] phase_q;
  logic [1:0] btn_q;
  logic       zero_q, pid_q;
  mode_e      mode_q;
  logic [1:0] dir_q;

  assign phase_o  = phase_q;
  assign pid_en_o = pid_q;
  assign busy_o   = state_q != ST_IDLE;
  assign done_o   = state_q == ST_OUT && out_free_i;
  assign mode_o   = mode_q;
  assign dir_o    = dir_q;

  always_comb begin
    cmd_o.load   = state_q == ST_IDLE && in_fire_i;
    cmd_o.step   = state_q == ST_MUL || state_q == ST_FIN;
    cmd_o.div_go = state_q == ST_MUL && phase_q == 3'd2;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      phase_q <= '0;
      btn_q   <= '0;
      zero_q  <= 1'b0;
      pid_q   <= 1'b0;
      mode_q  <= MODE_STOP_FWD;
      dir_q   <= '0;
    end else begin
      unique case (state_q)
        ST_IDLE: if (in_fire_i) begin
          btn_q   <= button_i;
          zero_q  <= meas_zero_i;
          pid_q   <= mode_q == MODE_RUN_CW || mode_q == MODE_RUN_CCW;
          phase_q <= '0;
          state_q <= ST_MUL;
        end
        ST_MUL: begin
          phase_q <= phase_q + 3'd1;
          if (phase_q == 3'd2) state_q <= ST_DIV;
        end
        ST_DIV: if (sts_i.div_done) state_q <= ST_FIN;
        ST_FIN: begin
          phase_q <= phase_q + 3'd1;
          if (phase_q == 3'd5) begin
            state_q <= ST_OUT;
            unique case (mode_q)
              MODE_STOP_FWD: if (btn_q == BTN_R) mode_q <= MODE_STOP_REV;
                else if (btn_q == BTN_S) mode_q <= MODE_ACCEL_CW;
              MODE_STOP_REV: if (btn_q == BTN_R) mode_q <= MODE_STOP_FWD;
                else if (btn_q == BTN_S) mode_q <= MODE_ACCEL_CCW;
              MODE_ACCEL_CW:  begin dir_q <= DIR_CW;  mode_q <= MODE_RUN_CW; end
              MODE_ACCEL_CCW: begin dir_q <= DIR_CCW; mode_q <= MODE_RUN_CCW; end
              MODE_RUN_CW: if (btn_q == BTN_R) mode_q <= MODE_REV_CCW;
                else if (btn_q == BTN_S) mode_q <= MODE_BRAKE_CW;
              MODE_RUN_CCW: if (btn_q == BTN_R) mode_q <= MODE_REV_CW;
                else if (btn_q == BTN_S) mode_q <= MODE_BRAKE_CCW;
              MODE_REV_CW:  begin dir_q <= DIR_CW;  mode_q <= MODE_ACCEL_CW; end
              MODE_REV_CCW: begin dir_q <= DIR_CCW; mode_q <= MODE_ACCEL_CCW; end
              MODE_BRAKE_CW:  if (zero_q) mode_q <= MODE_STOP_FWD;
              MODE_BRAKE_CCW: if (zero_q) mode_q <= MODE_STOP_REV;
              default: mode_q <= MODE_STOP_FWD;
            endcase
          end
        end
        ST_OUT: if (out_free_i) state_q <= ST_IDLE;
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule

>>> rtl/core/motor_mode_sequencer_pid.sv
// Top level of the motor mode sequencer with PID speed control.
// Depends on mmsp_pkg, mmsp_ctrl, mmsp_datapath.
//
// One input word is one control tick and gives one output word. Three multiplies
// share one multiplier, then a restoring divider produces one quotient bit per
// cycle over 50 bits for the derivative term, then the integral update, derivative
// load and duty clamp follow. No new word is accepted while one is in progress;
// the next word is taken once the result is loaded into the output register.
module motor_mode_sequencer_pid
  import mmsp_pkg::*;
#(
  parameter int unsigned DUTY_MAX = 4095
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [31:0] cfg_data_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,  // speed_measured, speed_target, elapsed_ms
  input  logic [1:0]  s_axis_tuser,  // button_event
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,  // pwm_duty, direction, brake_active, mode, pad
  output logic        m_axis_tuser
);

  dp_cmd_t cmd;
  dp_sts_t sts;
  logic [2:0] phase;
  logic pid_en, busy, done;
  logic [3:0] mode;
  logic [1:0] dir;
  logic [11:0] duty;
  logic valid_q;
  logic [18:0] word_q;
  logic out_free;

  assign out_free      = !valid_q || m_axis_tready;
  assign s_axis_tready = !busy;
  assign m_axis_tuser  = 1'b0;

  mmsp_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_fire_i   (s_axis_tvalid && s_axis_tready),
    .button_i    (s_axis_tuser),
    .meas_zero_i (s_axis_tdata[15:0] == 16'd0),
    .sts_i       (sts),
    .out_free_i  (out_free),
    .cmd_o       (cmd),
    .phase_o     (phase),
    .pid_en_o    (pid_en),
    .busy_o      (busy),
    .done_o      (done),
    .mode_o      (mode),
    .dir_o       (dir)
  );

  mmsp_datapath #(.DutyMax(DUTY_MAX)) u_dp (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .cmd_i     (cmd),
    .phase_i   (phase),
    .pid_en_i  (pid_en),
    .meas_i    (s_axis_tdata[15:0]),
    .target_i  (s_axis_tdata[31:16]),
    .elapsed_i (s_axis_tdata[47:32]),
    .sts_o     (sts),
    .duty_o    (duty)
  );

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      word_q  <= '0;
    end else begin
      if (done) begin
        valid_q <= 1'b1;
        word_q  <= {mode, (mode == MODE_BRAKE_CW || mode == MODE_BRAKE_CCW), dir, duty};
      end else if (m_axis_tready) begin
        valid_q <= 1'b0;
      end
    end
  end

  assign m_axis_tvalid = valid_q;
  assign m_axis_tdata  = {5'd0, word_q};

endmodule

>>> rtl/core/mmsp_checker.sv
// Port-level checker for the motor mode sequencer, bound to the top level.
// Depends on mmsp_pkg.
module mmsp_checker
  import mmsp_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [23:0] m_axis_tdata
);

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata)) else $error("held word changed");

  a_mode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[18:15] <= 4'd9) else $error("bad mode");

  a_brake: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[14] ==
      (m_axis_tdata[18:15] == 4'd8 || m_axis_tdata[18:15] == 4'd9)) else $error("brake flag");

  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready) else $error("took two words");

endmodule

bind motor_mode_sequencer_pid mmsp_checker u_chk (.*);
